// File: rtl/nfba_pkg.sv
// Package for the next-fit bitmap allocator.
// Holds the beat types of both channels, the action codes and the word-scan result type.
// Depends on nothing.
package nfba_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned TOTAL_W   = 11;

  localparam logic [1:0] ACT_ALLOC    = 2'd0;
  localparam logic [1:0] ACT_WR_WORD  = 2'd1;
  localparam logic [1:0] ACT_SET_POS  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [4:0]  word_index;
    logic [31:0] word_value;
    logic [9:0]  start_position;
    logic [10:0] free_count_in;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] entry_number;
    logic       none_free;
  } out_beat_t;

  typedef struct packed {
    logic        found;
    logic [4:0]  bit_idx;
    logic [31:0] cleared;
  } hit_t;

endpackage

// File: rtl/nfba_word_scan.sv
// Finds the lowest free bit of one bitmap word inside a window of bit offsets.
// Depends on nfba_pkg for the hit_t result type.
module nfba_word_scan (
  input  logic [31:0]   word_i,
  input  logic [4:0]    lo_i,
  input  logic [4:0]    hi_i,
  output nfba_pkg::hit_t hit_o
);

  logic [31:0] lo_mask;
  logic [31:0] hi_mask;
  logic [31:0] cand;
  logic [4:0]  idx;

  assign lo_mask = 32'hFFFF_FFFF << lo_i;
  assign hi_mask = 32'hFFFF_FFFF >> (5'd31 - hi_i);
  assign cand    = word_i & lo_mask & hi_mask;

  // Walk downwards so that the lowest set bit wins.
  always_comb begin
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (cand[i]) begin
        idx = 5'(i);
      end
    end
  end

  assign hit_o.found   = |cand;
  assign hit_o.bit_idx = idx;
  assign hit_o.cleared = word_i & ~(32'd1 << idx);

endmodule

// File: rtl/next_fit_bitmap_allocator_top.sv
// Top level of the next-fit bitmap allocator: control, bitmap memory and result register.
// Depends on nfba_pkg and nfba_word_scan.
//
// Usage: items arrive on in_valid_i / in_stall_o / in_data_i and each yields exactly one
// result beat on out_valid_o / out_stall_i / out_data_o. The wrap limit total_inodes is
// written through cfg_valid_i / cfg_ready_o / cfg_data_i; cfg_ready_o is always high and
// the port should only be written while the block is idle.
// Items are handled one at a time, and the next item is taken once the block is back
// in its idle state. Bitmap-word and position loads, and an allocate with a zero free
// count, go from the execute state through the response state into the output register.
// An allocate scans one 32-bit word per cycle from the synchronous bitmap memory,
// issuing a new read every cycle while the previous word is evaluated, before its result
// goes through the response state; the scan stops at the word holding the first free
// entry, or after the whole window when nothing is found, having read at most
// ceil(window/32) + 1 words, where window is min(max(total_inodes,1), NUM_ENTRIES).
// After reset the bitmap reads as all zero through per-word valid bits, the position and
// free count are zero and total_inodes is 1024; no clearing pass is needed.
// The result sits in an output register; a stalled receiver holds it there, and a new
// item is still taken, but its own result waits until that register has been drained.
module next_fit_bitmap_allocator_top #(
  parameter int unsigned NUM_ENTRIES = 1024
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  nfba_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nfba_pkg::out_beat_t  out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [10:0]          cfg_data_i
);

  localparam int unsigned AW        = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned TW        = (AW > nfba_pkg::TOTAL_W) ? AW : nfba_pkg::TOTAL_W;
  localparam int unsigned NP_W      = (AW > 10) ? AW : 10;
  localparam int unsigned MAP_WORDS = (NUM_ENTRIES + 31) / 32;
  localparam int unsigned MEM_WORDS = (MAP_WORDS > 32) ? 32 : MAP_WORDS;
  localparam int unsigned MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned WI_W      = AW - 5;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  nfba_pkg::in_beat_t      item_q;
  nfba_pkg::out_beat_t     res_q, res_d;
  nfba_pkg::out_beat_t     out_q;
  logic                    out_vld_q;
  logic [10:0]             total_q;
  logic [NP_W-1:0]         next_pos_q;
  logic [10:0]             count_q;

  // Bitmap memory; words beyond the writable range are never stored and read as zero.
  logic [31:0]             mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0]    wvalid_q;
  logic                    mem_we;
  logic [MEM_AW-1:0]       mem_waddr;
  logic [31:0]             mem_wdata;
  logic [31:0]             rd_word_q;
  logic                    rd_ok_q;
  logic [31:0]             rd_word;

  // Address generation stage.
  logic [AW-1:0]           cur_q, rem_q, lim_q;
  logic [4:0]              off;
  logic [AW-1:0]           room, to_wrap, n_a, n;
  logic [AW:0]             cur_sum;
  logic [AW-1:0]           rem_next;
  logic                    issue;
  logic [WI_W-1:0]         cur_word;
  logic                    cur_in_mem;

  // Evaluation stage.
  logic                    e_vld_q;
  logic [WI_W-1:0]         e_word_q;
  logic [4:0]              e_lo_q, e_hi_q;
  logic                    e_last_q;
  nfba_pkg::hit_t          hit;
  logic [AW-1:0]           hit_pos;

  // Start of scan.
  logic [TW-1:0]           tot_ext, lim_ext;
  logic [NP_W:0]           start_inc;
  logic [AW-1:0]           first_pos;
  logic                    wr_in_range;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Scan window: min(max(total_inodes,1), NUM_ENTRIES) entries, and the first entry
  // after the stored position inside it.
  always_comb begin
    tot_ext = TW'(total_q);
    lim_ext = (tot_ext == '0) ? TW'(1) : tot_ext;
    if (lim_ext > TW'(NUM_ENTRIES)) begin
      lim_ext = TW'(NUM_ENTRIES);
    end
    start_inc = {1'b0, next_pos_q} + (NP_W + 1)'(1);
    first_pos = (start_inc < (NP_W + 1)'(lim_ext)) ? AW'(start_inc) : '0;
  end

  assign wr_in_range = ({1'b0, item_q.word_index} < 6'(MEM_WORDS));

  // One word visited per issued read: from the current offset up to the word end,
  // the wrap point or the remaining entry count, whichever is nearest.
  always_comb begin
    off      = cur_q[4:0];
    room     = AW'(6'd32 - {1'b0, off});
    to_wrap  = lim_q - cur_q;
    n_a      = (room < to_wrap) ? room : to_wrap;
    n        = (n_a < rem_q) ? n_a : rem_q;
    cur_sum  = {1'b0, cur_q} + {1'b0, n};
    rem_next = rem_q - n;
    issue    = (state_q == ST_SCAN) && (rem_q != '0);
    cur_word = cur_q[AW-1:5];
    cur_in_mem = ({1'b0, cur_word} < (WI_W + 1)'(MEM_WORDS));
  end

  assign rd_word = rd_ok_q ? rd_word_q : 32'd0;

  nfba_word_scan u_scan (
    .word_i (rd_word),
    .lo_i   (e_lo_q),
    .hi_i   (e_hi_q),
    .hit_o  (hit)
  );

  assign hit_pos = {e_word_q, hit.bit_idx};

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = item_q.word_index[MEM_AW-1:0];
    mem_wdata = item_q.word_value;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d.entry_number = '0;
        res_d.none_free    = 1'b0;
        if (item_q.action == nfba_pkg::ACT_WR_WORD) begin
          mem_we  = wr_in_range;
          state_d = ST_RESP;
        end else if (item_q.action == nfba_pkg::ACT_ALLOC && count_q != '0) begin
          state_d = ST_SCAN;
        end else begin
          res_d.none_free = (item_q.action == nfba_pkg::ACT_ALLOC);
          state_d         = ST_RESP;
        end
      end
      ST_SCAN: begin
        if (e_vld_q && hit.found) begin
          // The read issued at this edge is dropped, so the write-back cannot race it.
          mem_we             = 1'b1;
          mem_waddr          = e_word_q[MEM_AW-1:0];
          mem_wdata          = hit.cleared;
          res_d.entry_number = 10'(hit_pos);
          state_d            = ST_RESP;
        end else if (e_vld_q && e_last_q) begin
          res_d.entry_number = 10'(next_pos_q);
          state_d            = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_vld_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      out_vld_q  <= 1'b0;
      total_q    <= 11'd1024;
      next_pos_q <= '0;
      count_q    <= '0;
      wvalid_q   <= '0;
      e_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        total_q <= cfg_data_i;
      end
      if (mem_we) begin
        wvalid_q[mem_waddr] <= 1'b1;
      end
      if (state_q == ST_EXEC && item_q.action == nfba_pkg::ACT_SET_POS) begin
        next_pos_q <= NP_W'(item_q.start_position);
        count_q    <= item_q.free_count_in;
      end
      if (state_q == ST_SCAN && state_d == ST_RESP) begin
        count_q <= count_q - 11'd1;
        if (hit.found) begin
          next_pos_q <= NP_W'(hit_pos);
        end
      end
      e_vld_q <= issue;
      if (state_q == ST_RESP && state_d == ST_IDLE) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload and scan registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    res_q <= res_d;
    if (state_q == ST_RESP && state_d == ST_IDLE) begin
      out_q <= res_q;
    end
    if (state_q == ST_EXEC) begin
      cur_q <= first_pos;
      rem_q <= AW'(lim_ext);
      lim_q <= AW'(lim_ext);
    end else if (issue) begin
      cur_q <= (cur_sum >= {1'b0, lim_q}) ? '0 : AW'(cur_sum);
      rem_q <= rem_next;
    end
    if (issue) begin
      e_word_q <= cur_word;
      e_lo_q   <= off;
      e_hi_q   <= 5'(off + 5'(n) - 5'd1);
      e_last_q <= (rem_next == '0);
    end
  end

  // Bitmap memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_word_q <= mem_q[cur_word[MEM_AW-1:0]];
      rd_ok_q   <= cur_in_mem && wvalid_q[cur_word[MEM_AW-1:0]];
    end
  end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the next-fit bitmap allocator top level.
// Needs nfba_pkg and next_fit_bitmap_allocator_top; an internal predictor supplies the
// expected beats.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned NUM_ENTRIES  = 1024;
  localparam int unsigned MAP_WORDS    = NUM_ENTRIES / nfba_pkg::WORD_BITS;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned LIMIT_CYCLES = 600000;

  typedef enum int {FILL_EMPTY, FILL_ONE, FILL_SPARSE, FILL_HALF, FILL_FULL} fill_e;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY} rx_mode_e;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  nfba_pkg::in_beat_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  nfba_pkg::out_beat_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [10:0]         cfg_data_i  = '0;

  // Predictor state.
  logic [31:0] map_words [MAP_WORDS];
  logic [9:0]  cur_pos;
  logic [10:0] free_left;
  logic [10:0] total_cfg;

  nfba_pkg::out_beat_t expected_q[$];
  int unsigned errors, cycles, items_sent, results_seen;
  int unsigned alloc_count, refused_count, empty_scan_count, cfg_writes;
  int unsigned burst_left;
  bit          pace_on;
  bit          hold_req;
  int unsigned hold_left, mode_left;
  rx_mode_e    rx_mode;

  next_fit_bitmap_allocator_top #(.NUM_ENTRIES(NUM_ENTRIES)) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d beats outstanding", cycles,
               expected_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    errors++;
    if (errors <= 40)
      $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // ---------------------------------------------------------------- predictor

  function automatic int unsigned scan_window(input logic [10:0] tot);
    if (tot == 0) return 1;
    if (tot > NUM_ENTRIES) return NUM_ENTRIES;
    return 32'(tot);
  endfunction

  function automatic int unsigned step_pos(input int unsigned p);
    if (p >= NUM_ENTRIES - 1 || p + 1 >= total_cfg) return 0;
    return p + 1;
  endfunction

  function automatic int unsigned count_free(input int unsigned win);
    int unsigned n;
    n = 0;
    for (int unsigned e = 0; e < win; e++)
      if (map_words[e[9:5]][e[4:0]]) n++;
    return n;
  endfunction

  function automatic nfba_pkg::out_beat_t allocate_next_fit(input nfba_pkg::in_beat_t b);
    nfba_pkg::out_beat_t r;
    int unsigned         p, lim;
    bit                  hit;
    r = '0;
    case (b.action)
      nfba_pkg::ACT_WR_WORD: map_words[b.word_index] = b.word_value;
      nfba_pkg::ACT_SET_POS: begin
        cur_pos   = b.start_position;
        free_left = b.free_count_in;
      end
      nfba_pkg::ACT_ALLOC: begin
        alloc_count++;
        if (free_left == 0) begin
          r.none_free = 1'b1;
          refused_count++;
        end else begin
          p   = 32'(cur_pos);
          lim = scan_window(total_cfg);
          hit = 1'b0;
          for (int unsigned i = 0; i < lim && !hit; i++) begin
            p = step_pos(p);
            if (map_words[p[9:5]][p[4:0]]) begin
              map_words[p[9:5]][p[4:0]] = 1'b0;
              hit = 1'b1;
            end
          end
          // A count that overstates the free entries leaves the position alone.
          if (!hit) begin
            p = 32'(cur_pos);
            empty_scan_count++;
          end
          cur_pos        = p[9:0];
          free_left      = free_left - 11'd1;
          r.entry_number = p[9:0];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic nfba_pkg::in_beat_t rand_beat(input logic [1:0] act);
    nfba_pkg::in_beat_t b;
    b.action         = act;
    b.word_index     = 5'($urandom);
    b.word_value     = $urandom;
    b.start_position = 10'($urandom);
    b.free_count_in  = 11'($urandom);
    return b;
  endfunction

  function automatic nfba_pkg::in_beat_t word_beat(input int unsigned idx,
                                                   input logic [31:0] val);
    nfba_pkg::in_beat_t b;
    b            = rand_beat(nfba_pkg::ACT_WR_WORD);
    b.word_index = idx[4:0];
    b.word_value = val;
    return b;
  endfunction

  function automatic nfba_pkg::in_beat_t position_beat(input int unsigned pos,
                                                       input int unsigned cnt);
    nfba_pkg::in_beat_t b;
    b                = rand_beat(nfba_pkg::ACT_SET_POS);
    b.start_position = pos[9:0];
    b.free_count_in  = cnt[10:0];
    return b;
  endfunction

  function automatic logic [31:0] word_fill(input fill_e dens);
    case (dens)
      FILL_EMPTY:  return 32'h0;
      FILL_ONE:    return 32'h1 << $urandom_range(0, 31);
      FILL_SPARSE: return $urandom & $urandom & $urandom;
      FILL_HALF:   return $urandom;
      default:     return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Valid is only lowered ahead of a gap, so it never gets two updates in one step.
  task automatic send_item(input nfba_pkg::in_beat_t b);
    if (pace_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
      burst_left = $urandom_range(1, 14);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(allocate_next_fit(b));
    items_sent++;
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_total(input logic [10:0] tot);
    drain_block();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tot;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    total_cfg = tot;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    nfba_pkg::out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", int'(out_data_o), 0);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o.entry_number !== want.entry_number)
          report_mismatch("entry_number", int'(out_data_o.entry_number),
                          int'(want.entry_number));
        if (out_data_o.none_free !== want.none_free)
          report_mismatch("none_free", int'(out_data_o.none_free), int'(want.none_free));
      end
    end
  end

  // Receiver: changes its stall habit every so often, and obeys a long hold-off request.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        rx_mode   = rx_mode_e'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      case (rx_mode)
        RX_OPEN:  out_stall_i <= 1'b0;
        RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        default:  out_stall_i <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_after_reset();
    nfba_pkg::in_beat_t b;
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    b = '1;
    b.action = ACT_UNUSED;
    send_item(b);
    send_item(word_beat(31, 32'hFFFF_FFFF));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
  endtask

  task automatic test_directed_allocs();
    send_item(word_beat(0, 32'h0000_0021));
    send_item(word_beat(31, 32'h8000_0000));
    send_item(position_beat(0, 2047));
    // Entry 5, top entry, wrap to entry zero, then a scan that finds nothing.
    repeat (4) send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    send_item(position_beat(1023, 0));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    send_item(word_beat(0, 32'hFFFF_FFFF));
    send_item(position_beat(1023, 1024));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
  endtask

  task automatic test_wrap_limits();
    // A zero limit behaves as one: only entry zero is looked at.
    write_total(11'd0);
    send_item(position_beat(700, 5));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    send_item(word_beat(0, 32'h0000_0001));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    // A start position beyond the window wraps straight to entry zero.
    write_total(11'd40);
    send_item(position_beat(500, 3));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    send_item(word_beat(1, 32'hFFFF_FFFF));
    send_item(rand_beat(nfba_pkg::ACT_ALLOC));
  endtask

  task automatic run_random_phase(input logic [10:0] tot, input int unsigned n_items);
    int unsigned win, words, sel, pos, cnt;
    fill_e       dens;
    write_total(tot);
    win     = scan_window(tot);
    words   = (win + nfba_pkg::WORD_BITS - 1) / nfba_pkg::WORD_BITS;
    dens    = fill_e'($urandom_range(0, 4));
    pace_on = ($urandom_range(0, 3) != 0);
    for (int unsigned w = 0; w < words; w++) send_item(word_beat(w, word_fill(dens)));
    for (int unsigned k = 0; k <= n_items; k++) begin
      sel = (k == 0) ? 90 : $urandom_range(0, 99);
      if (sel < 72) begin
        send_item(rand_beat(nfba_pkg::ACT_ALLOC));
      end else if (sel < 84) begin
        if ($urandom_range(0, 4) != 0)
          send_item(word_beat($urandom_range(0, words - 1),
                              word_fill(fill_e'($urandom_range(0, 4)))));
        else
          send_item(rand_beat(nfba_pkg::ACT_WR_WORD));
      end else if (sel < 95) begin
        pos = ($urandom_range(0, 6) != 0) ? $urandom_range(0, win - 1) : $urandom_range(0, 1023);
        case ($urandom_range(0, 3))
          0, 1:    cnt = count_free(win);
          2:       cnt = $urandom_range(0, 12);
          default: cnt = $urandom_range(0, 2047);
        endcase
        send_item(position_beat(pos, cnt));
      end else begin
        send_item(rand_beat(ACT_UNUSED));
      end
    end
  endtask

  task automatic test_random_phases();
    logic [10:0] totals [9] = '{11'd1024, 11'd40, 11'd1, 11'd0, 11'd2047, 11'd333,
                                11'd64, 11'd1000, 11'd7};
    int unsigned lens [9]   = '{45, 50, 30, 25, 40, 50, 50, 40, 35};
    for (int i = 0; i < 9; i++) run_random_phase(totals[i], lens[i]);
    pace_on = 1'b1;
  endtask

  task automatic test_stall_pressure();
    write_total(11'd256);
    for (int unsigned w = 0; w < 8; w++) send_item(word_beat(w, word_fill(FILL_HALF)));
    send_item(position_beat($urandom_range(0, 255), count_free(256)));
    // Hold the output off while beats keep coming, so the input has to stall.
    pace_on  = 1'b0;
    hold_req = 1'b1;
    repeat (30) send_item(rand_beat(nfba_pkg::ACT_ALLOC));
    pace_on  = 1'b1;
  endtask

  initial begin
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= '0;
    rst_ni      <= 1'b0;
    foreach (map_words[i]) map_words[i] = '0;
    cur_pos   = '0;
    free_left = '0;
    total_cfg = 11'd1024;
    pace_on   = 1'b1;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    test_after_reset();
    test_directed_allocs();
    test_wrap_limits();
    test_random_phases();
    test_stall_pressure();

    drain_block();
    repeat (40) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("result beats never delivered", 0, expected_q.size());

    $display("Sent %0d items over %0d wrap limits, checked %0d result beats.",
             items_sent, cfg_writes, results_seen);
    $display("Allocations: %0d, refused on zero count: %0d, scans finding nothing: %0d.",
             alloc_count, refused_count, empty_scan_count);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
